// ----- rtl/core/bstod_pkg.sv -----
// ----------------------------------------------------------------------------
// bstod_pkg
// Shared types, constants and time arithmetic for the time-of-day clock.
// ----------------------------------------------------------------------------
package bstod_pkg;

	localparam int CNT_W     = 10;
	localparam int DEB_W     = 8;
	localparam int BTN_W     = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 10;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	localparam logic CMD_TICK   = 1'b0;
	localparam logic CMD_BUTTON = 1'b1;

	localparam int BTN_MIN  = 0;
	localparam int BTN_SEC  = 1;
	localparam int BTN_DOWN = 2;
	localparam int BTN_HOUR = 3;
	localparam int BTN_UP   = 4;

	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_TICKS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT_TICKS     = 3'd4;

	localparam logic [CNT_W-1:0] RST_TICKS_PER_SECOND = 10'd100;
	localparam logic [CNT_W-1:0] RST_DISPLAY_TICKS    = 10'd20;
	localparam logic [DEB_W-1:0] RST_DEBOUNCE_TICKS   = 8'd7;
	localparam logic [CNT_W-1:0] RST_HOLD_TICKS       = 10'd100;
	localparam logic [CNT_W-1:0] RST_REPEAT_TICKS     = 10'd50;

	localparam logic [4:0] HOUR_LAST = 5'd23;
	localparam logic [5:0] MS_LAST   = 6'd59;

	typedef struct packed {
		logic             cmd;
		logic [BTN_W-1:0] buttons;
	} in_t;

	typedef struct packed {
		logic [4:0] hour_now;
		logic [5:0] minute_now;
		logic [5:0] second_now;
		logic       refresh;
	} out_t;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} time_t;

	// events for one tick, from the counter unit to the time unit
	typedef struct packed {
		logic             sec_step;
		logic             apply_latch;
		logic             apply_repeat;
		logic [BTN_W-1:0] buttons;
		logic             refresh;
	} ev_t;

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
		return (v == CNT_MAX) ? v : v + 1'b1;
	endfunction

	function automatic logic [4:0] hour_up(logic [4:0] v);
		return (v >= HOUR_LAST) ? 5'd0 : v + 5'd1;
	endfunction

	function automatic logic [4:0] hour_down(logic [4:0] v);
		return (v == 5'd0 || v > HOUR_LAST) ? HOUR_LAST : v - 5'd1;
	endfunction

	function automatic logic [5:0] ms_up(logic [5:0] v);
		return (v >= MS_LAST) ? 6'd0 : v + 6'd1;
	endfunction

	function automatic logic [5:0] ms_down(logic [5:0] v);
		return (v == 6'd0 || v > MS_LAST) ? MS_LAST : v - 6'd1;
	endfunction

	function automatic time_t apply_btn(time_t t, logic [BTN_W-1:0] b);
		time_t r;
		r = t;
		if (b[BTN_DOWN]) begin
			if (b[BTN_HOUR]) r.hour   = hour_down(r.hour);
			if (b[BTN_MIN])  r.minute = ms_down(r.minute);
			if (b[BTN_SEC])  r.second = ms_down(r.second);
		end
		if (b[BTN_UP]) begin
			if (b[BTN_HOUR]) r.hour   = hour_up(r.hour);
			if (b[BTN_MIN])  r.minute = ms_up(r.minute);
			if (b[BTN_SEC])  r.second = ms_up(r.second);
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/bstod_ctrl.sv -----
// ----------------------------------------------------------------------------
// bstod_ctrl
// Configuration registers, interval counters and button debounce/repeat.
// ----------------------------------------------------------------------------
module bstod_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bstod_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bstod_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                          fire,
	input  bstod_pkg::in_t                item,
	output bstod_pkg::ev_t                ev
);
	import bstod_pkg::*;

	logic [CNT_W-1:0] tps_q, disp_q, hold_q, rep_q;
	logic [DEB_W-1:0] deb_q;
	logic [CNT_W-1:0] sec_cnt_q, ref_cnt_q, rep_cnt_q, settle_q;
	logic [BTN_W-1:0] raw_q, latched_q;

	logic [CNT_W-1:0] sec_inc, ref_inc, rep_inc;
	logic             sec_hit, ref_hit, latch, rep_hit;
	logic [BTN_W-1:0] latched_nxt;

	always_comb begin
		sec_inc     = sat_inc(sec_cnt_q);
		ref_inc     = sat_inc(ref_cnt_q);
		rep_inc     = sat_inc(rep_cnt_q);
		sec_hit     = sec_inc >= tps_q;
		ref_hit     = ref_inc >= disp_q;
		latch       = settle_q == {{(CNT_W-DEB_W){1'b0}}, deb_q};
		latched_nxt = latch ? raw_q : latched_q;
		rep_hit     = (settle_q >= hold_q) && (rep_inc >= rep_q);
		ev.sec_step     = sec_hit && (latched_q == '0);
		ev.apply_latch  = latch && (raw_q != '0);
		ev.apply_repeat = rep_hit;
		ev.buttons      = latched_nxt;
		ev.refresh      = ref_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q  <= RST_TICKS_PER_SECOND;
			disp_q <= RST_DISPLAY_TICKS;
			deb_q  <= RST_DEBOUNCE_TICKS;
			hold_q <= RST_HOLD_TICKS;
			rep_q  <= RST_REPEAT_TICKS;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICKS_PER_SECOND: tps_q  <= cfg_data;
				REG_DISPLAY_TICKS:    disp_q <= cfg_data;
				REG_DEBOUNCE_TICKS:   deb_q  <= cfg_data[DEB_W-1:0];
				REG_HOLD_TICKS:       hold_q <= cfg_data;
				REG_REPEAT_TICKS:     rep_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_cnt_q <= '0;
			ref_cnt_q <= '0;
			rep_cnt_q <= '0;
			settle_q  <= '0;
			raw_q     <= '0;
			latched_q <= '0;
		end else if (fire) begin
			if (item.cmd == CMD_TICK) begin
				sec_cnt_q <= sec_hit ? '0 : sec_inc;
				ref_cnt_q <= ref_hit ? '0 : ref_inc;
				rep_cnt_q <= rep_hit ? '0 : rep_inc;
				settle_q  <= sat_inc(settle_q);
				latched_q <= latched_nxt;
			end else begin
				raw_q    <= item.buttons;
				settle_q <= '0;
			end
		end
	end

endmodule

// ----- rtl/core/bstod_time.sv -----
// ----------------------------------------------------------------------------
// bstod_time
// Hours, minutes and seconds: one-second step with carry, button adjust.
// ----------------------------------------------------------------------------
module bstod_time (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic             tick,
	input  bstod_pkg::ev_t   ev,
	output bstod_pkg::time_t time_nxt
);
	import bstod_pkg::*;

	time_t now_q;
	time_t stepped, adj1, adj2;

	always_comb begin
		stepped = now_q;
		if (ev.sec_step) begin
			stepped.second = ms_up(now_q.second);
			if (stepped.second == 6'd0) begin
				stepped.minute = ms_up(now_q.minute);
				if (stepped.minute == 6'd0) stepped.hour = hour_up(now_q.hour);
			end
		end
		adj1 = ev.apply_latch ? apply_btn(stepped, ev.buttons) : stepped;
		adj2 = ev.apply_repeat ? apply_btn(adj1, ev.buttons) : adj1;
		time_nxt = tick ? adj2 : now_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
		end else if (fire) begin
			now_q <= time_nxt;
		end
	end

endmodule

// ----- rtl/core/button_set_time_of_day_clock.sv -----
// ----------------------------------------------------------------------------
// button_set_time_of_day_clock
// 24-hour clock advanced by tick items and set by debounced push buttons.
// ----------------------------------------------------------------------------
// Usage:
//   in_data carries one item per transfer: cmd = 0 is a timer tick,
//   cmd = 1 a button change with the raw button levels in buttons.
//   Every item yields exactly one result on out_data: the time after
//   the item and the refresh strobe (always 0 for a button change).
//   An item sits in the input register after its transfer and then moves
//   to the result register, which raises out_valid. Throughput: one item
//   per cycle while out_ready keeps the result register draining; the
//   update of counters and time is one short pass of logic.
//   in_ready stays high while the input register is empty or the result
//   register is empty or being taken, so the input register is a one-deep
//   skid stage: when out_ready is low, one more item is held and then
//   in_ready drops.
//   Configuration is written through cfg_we/cfg_index/cfg_data; the user
//   writes it only while no item is in flight, which the block does not
//   enforce. Unused indexes are ignored. Reset (arst_n low) clears time,
//   counters and buttons, empties both stages, restores register defaults.
// ----------------------------------------------------------------------------
module button_set_time_of_day_clock (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [bstod_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bstod_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  bstod_pkg::in_t                  in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output bstod_pkg::out_t                 out_data
);
	import bstod_pkg::*;

	logic  valid_s1;
	in_t   item_s1;
	logic  out_valid_q;
	out_t  out_q;
	logic  advance, fire, tick;
	ev_t   ev;
	time_t time_nxt;

	assign advance  = !out_valid_q || out_ready;
	assign fire     = valid_s1 && advance;
	assign tick     = item_s1.cmd == CMD_TICK;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_data;
	end

	bstod_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fire      (fire),
		.item      (item_s1),
		.ev        (ev)
	);

	bstod_time u_time (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.tick     (tick),
		.ev       (ev),
		.time_nxt (time_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.hour_now   <= time_nxt.hour;
			out_q.minute_now <= time_nxt.minute;
			out_q.second_now <= time_nxt.second;
			out_q.refresh    <= tick && ev.refresh;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_fire_lands: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed item did not reach the result register");

	a_button_no_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !tick) |=> !out_q.refresh)
		else $error("refresh set on a button change");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.hour_now <= HOUR_LAST && out_q.minute_now <= MS_LAST
			&& out_q.second_now <= MS_LAST))
		else $error("time field out of range");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stalled while a stage is free");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the button-set time-of-day clock. Items stream in
// bursts from a pending queue, an item-level model of the clock predicts
// every result, and results are checked in order under a varying receiver
// stall pattern. Register settings change between drained phases.
// ----------------------------------------------------------------------------
module tb;
	import bstod_pkg::*;

	localparam int CLK_HALF     = 2;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_MAX   = 10;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam logic [BTN_W-1:0] KEY_MIN  = BTN_W'(1 << BTN_MIN);
	localparam logic [BTN_W-1:0] KEY_SEC  = BTN_W'(1 << BTN_SEC);
	localparam logic [BTN_W-1:0] KEY_DOWN = BTN_W'(1 << BTN_DOWN);
	localparam logic [BTN_W-1:0] KEY_HOUR = BTN_W'(1 << BTN_HOUR);
	localparam logic [BTN_W-1:0] KEY_UP   = BTN_W'(1 << BTN_UP);

	typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_e;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_t                  in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_t                 out_data;

	// clock model: settings and state
	logic [CNT_W-1:0] set_tps, set_disp, set_hold, set_rep;
	logic [DEB_W-1:0] set_deb;
	logic [CNT_W-1:0] sec_div, disp_div, rep_div, settle;
	logic [BTN_W-1:0] raw_keys, held_keys;
	logic [4:0]       hr;
	logic [5:0]       mn, sc;

	in_t      pending_items[$];
	out_t     expected_times[$];
	int       mismatch_count = 0;
	int       cycle_count    = 0;
	int       burst_left     = 0;
	int       gap_left       = 0;
	int       rx_left        = 0;
	rx_mode_e rx_mode        = RX_STREAM;

	button_set_time_of_day_clock i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	function automatic logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// manual adjust: decrement first, then increment, no carry between fields
	function automatic void nudge_time(logic [BTN_W-1:0] b);
		if (b[BTN_DOWN]) begin
			if (b[BTN_HOUR]) hr = (hr == 5'd0) ? 5'd23 : hr - 5'd1;
			if (b[BTN_MIN])  mn = (mn == 6'd0) ? 6'd59 : mn - 6'd1;
			if (b[BTN_SEC])  sc = (sc == 6'd0) ? 6'd59 : sc - 6'd1;
		end
		if (b[BTN_UP]) begin
			if (b[BTN_HOUR]) hr = (hr >= 5'd23) ? 5'd0 : hr + 5'd1;
			if (b[BTN_MIN])  mn = (mn >= 6'd59) ? 6'd0 : mn + 6'd1;
			if (b[BTN_SEC])  sc = (sc >= 6'd59) ? 6'd0 : sc + 6'd1;
		end
	endfunction

	function automatic out_t step_clock(in_t item);
		out_t r;
		r = '0;
		if (item.cmd == CMD_TICK) begin
			sec_div  = count_up(sec_div);
			disp_div = count_up(disp_div);
			rep_div  = count_up(rep_div);
			if (sec_div >= set_tps) begin
				if (held_keys == '0) begin
					sc = (sc >= 6'd59) ? 6'd0 : sc + 6'd1;
					if (sc == 6'd0) begin
						mn = (mn >= 6'd59) ? 6'd0 : mn + 6'd1;
						if (mn == 6'd0)
							hr = (hr >= 5'd23) ? 5'd0 : hr + 5'd1;
					end
				end
				sec_div = '0;
			end
			if (disp_div >= set_disp) begin
				r.refresh = 1'b1;
				disp_div  = '0;
			end
			if (settle == {2'b00, set_deb}) begin
				held_keys = raw_keys;
				if (held_keys != '0)
					nudge_time(held_keys);
			end
			if (settle >= set_hold && rep_div >= set_rep) begin
				nudge_time(held_keys);
				rep_div = '0;
			end
			settle = count_up(settle);
		end else begin
			raw_keys = item.buttons;
			settle   = '0;
		end
		r.hour_now   = hr;
		r.minute_now = mn;
		r.second_now = sc;
		return r;
	endfunction

	// leaves cfg_we high so writes can go back to back
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_TICKS_PER_SECOND: set_tps  = val;
			REG_DISPLAY_TICKS:    set_disp = val;
			REG_DEBOUNCE_TICKS:   set_deb  = val[DEB_W-1:0];
			REG_HOLD_TICKS:       set_hold = val;
			REG_REPEAT_TICKS:     set_rep  = val;
			default: ;
		endcase
	endtask

	task automatic program_clock(int tps, int disp, int deb, int hold, int rep);
		write_reg(REG_TICKS_PER_SECOND, CFG_DAT_W'(tps));
		write_reg(REG_DISPLAY_TICKS, CFG_DAT_W'(disp));
		write_reg(REG_DEBOUNCE_TICKS, CFG_DAT_W'(deb));
		write_reg(REG_HOLD_TICKS, CFG_DAT_W'(hold));
		write_reg(REG_REPEAT_TICKS, CFG_DAT_W'(rep));
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic push_item(logic cmd, logic [BTN_W-1:0] keys);
		in_t it;
		it.cmd     = cmd;
		it.buttons = keys;
		pending_items.push_back(it);
	endtask

	// tick items carry random junk in the ignored button field
	task automatic push_ticks(int n);
		repeat (n) push_item(CMD_TICK, BTN_W'($urandom_range(0, 31)));
	endtask

	// press, hold for a random number of ticks, usually release; some noise
	task automatic load_sessions(int count, int max_run);
		int               added;
		int               run;
		logic [BTN_W-1:0] keys;
		added = 0;
		while (added < count) begin
			if ($urandom_range(0, 6) == 0) begin
				push_item($urandom_range(0, 1) ? CMD_BUTTON : CMD_TICK,
					BTN_W'($urandom_range(0, 31)));
				added++;
			end else begin
				keys = BTN_W'($urandom_range(1, 31));
				if ($urandom_range(0, 1))
					keys = keys | ($urandom_range(0, 1) ? KEY_UP : KEY_DOWN);
				push_item(CMD_BUTTON, keys);
				run = $urandom_range(0, max_run);
				push_ticks(run);
				added += run + 1;
				if ($urandom_range(0, 2) != 0) begin
					push_item(CMD_BUTTON, '0);
					run = $urandom_range(0, max_run);
					push_ticks(run);
					added += run + 1;
				end
			end
		end
	endtask

	task automatic drain_results();
		while (pending_items.size() != 0 || in_valid || expected_times.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// sender: bursts of random length, random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_data    <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_times.push_back(step_clock(in_data));
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					in_data  <= pending_items.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 16);
						gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each transfer, stalls in changing modes
	always @(posedge clk or negedge arst_n) begin : result_monitor
		out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_left   <= 0;
			rx_mode   <= RX_STREAM;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_times.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX)
						$display("%0t: result %0d:%0d:%0d refresh %0b with none expected",
							$time, out_data.hour_now, out_data.minute_now,
							out_data.second_now, out_data.refresh);
				end else begin
					want = expected_times.pop_front();
					if (out_data.hour_now !== want.hour_now ||
					    out_data.minute_now !== want.minute_now ||
					    out_data.second_now !== want.second_now ||
					    out_data.refresh !== want.refresh) begin
						mismatch_count++;
						if (mismatch_count <= REPORT_MAX)
							$display("%0t: expected %0d:%0d:%0d refresh %0b, got %0d:%0d:%0d refresh %0b",
								$time, want.hour_now, want.minute_now, want.second_now,
								want.refresh, out_data.hour_now, out_data.minute_now,
								out_data.second_now, out_data.refresh);
					end
				end
			end
			if (rx_left == 0) begin
				rx_mode <= rx_mode_e'($urandom_range(0, 3));
				rx_left <= $urandom_range(8, 64);
			end else begin
				rx_left <= rx_left - 1;
			end
			case (rx_mode)
				RX_STREAM: out_ready <= 1'b1;
				RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
				default:   out_ready <= rx_left[2];
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("button_set_time_of_day_clock verification failed");
			$finish;
		end
	end

	initial begin
		set_tps   = RST_TICKS_PER_SECOND;
		set_disp  = RST_DISPLAY_TICKS;
		set_deb   = RST_DEBOUNCE_TICKS;
		set_hold  = RST_HOLD_TICKS;
		set_rep   = RST_REPEAT_TICKS;
		sec_div   = '0;
		disp_div  = '0;
		rep_div   = '0;
		settle    = '0;
		raw_keys  = '0;
		held_keys = '0;
		hr        = '0;
		mn        = '0;
		sc        = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults
		load_sessions(50, 20);
		drain_results();

		// directed: each field adjusted up and down, up and down together, a select
		// without a direction, ignored buttons on ticks, latch on the first tick
		write_reg(REG_SPARE_LO, '1);
		write_reg(REG_SPARE_HI, 10'h2AA);
		program_clock(3, 2, 0, 3, 2);
		push_item(CMD_TICK, '0);
		push_item(CMD_TICK, '1);
		push_item(CMD_BUTTON, KEY_DOWN | KEY_HOUR);
		push_ticks(3);
		push_item(CMD_BUTTON, KEY_UP | KEY_MIN);
		push_ticks(2);
		push_item(CMD_BUTTON, KEY_UP | KEY_SEC);
		push_ticks(1);
		push_item(CMD_BUTTON, '1);
		push_ticks(1);
		push_item(CMD_BUTTON, KEY_DOWN | KEY_SEC);
		push_ticks(1);
		push_item(CMD_BUTTON, KEY_MIN | KEY_SEC);
		push_ticks(1);
		push_item(CMD_BUTTON, '0);
		push_ticks(3);
		drain_results();

		program_clock(1, 1, 1, 4, 1);
		load_sessions(50, 12);
		drain_results();

		// zero intervals: second, refresh and repeat intervals expire on every tick
		program_clock(0, 0, 0, 0, 0);
		load_sessions(40, 8);
		drain_results();

		program_clock(5, 7, 3, 10, 3);
		load_sessions(50, 20);
		drain_results();

		// widest settings: nothing fires within a short hold
		program_clock(1023, 1023, 255, 1023, 1);
		push_item(CMD_BUTTON, KEY_UP | KEY_HOUR | KEY_MIN | KEY_SEC);
		push_ticks(24);
		push_item(CMD_BUTTON, '0);
		push_ticks(8);
		drain_results();

		repeat (3) begin
			program_clock($urandom_range(1, 20), $urandom_range(1, 20),
				$urandom_range(0, 10), $urandom_range(0, 20), $urandom_range(0, 8));
			load_sessions(40, set_deb + set_hold + 3 * set_rep + 6);
			drain_results();
		end

		if (mismatch_count == 0) begin
			$display("button_set_time_of_day_clock verification clean");
		end else begin
			$display("button_set_time_of_day_clock verification failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/bstod_pkg.sv
rtl/core/bstod_ctrl.sv
rtl/core/bstod_time.sv
rtl/core/button_set_time_of_day_clock.sv
tb/tb.sv
